// ----- hw/rtl/serial_word_unmasker_counter_keyed_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the serial word unmasker
// Shared property forms used by the RTL modules of this block.
// ----------------------------------------------------------------------------
`ifndef SERIAL_WORD_UNMASKER_COUNTER_KEYED_ASSERT_SVH
`define SERIAL_WORD_UNMASKER_COUNTER_KEYED_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWUCK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define SWUCK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/swuck_pkg.sv -----
// ----------------------------------------------------------------------------
// swuck_pkg
// Types, constants and permutation helpers of the serial word unmasker.
// ----------------------------------------------------------------------------
`default_nettype none

package swuck_pkg;

	localparam int unsigned WORD_W  = 16;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned SEED_W  = 4;

	// Item codes carried in the op field.
	localparam logic OP_DECRYPT = 1'b0;
	localparam logic OP_INIT    = 1'b1;

	localparam logic [WORD_W-1:0] MASK_CONST   = 16'hecbe;
	localparam logic [WORD_W-1:0] SEED_UNKNOWN = 16'd16;

	// Entry k names the source bit of result bit 15-k.
	typedef logic [3:0] perm_t [16];

	localparam perm_t PERM_IN = '{4'd9, 4'd13, 4'd15, 4'd7, 4'd14, 4'd8, 4'd6, 4'd10,
	                              4'd11, 4'd12, 4'd3, 4'd5, 4'd0, 4'd1, 4'd4, 4'd2};
	localparam perm_t PERM_C  = '{4'd6, 4'd11, 4'd3, 4'd1, 4'd13, 4'd5, 4'd15, 4'd10,
	                              4'd2, 4'd9, 4'd8, 4'd4, 4'd0, 4'd12, 4'd7, 4'd14};
	localparam perm_t PERM_P  = '{4'd9, 4'd7, 4'd5, 4'd2, 4'd14, 4'd4, 4'd13, 4'd8,
	                              4'd0, 4'd15, 4'd10, 4'd1, 4'd3, 4'd6, 4'd12, 4'd11};

	typedef logic [WORD_W-1:0] seed_tab_t [16];

	localparam seed_tab_t SEED_TABLE = '{
		SEED_UNKNOWN, SEED_UNKNOWN, SEED_UNKNOWN, 16'd0,
		16'd4,        16'd9,        SEED_UNKNOWN, SEED_UNKNOWN,
		SEED_UNKNOWN, 16'd8,        SEED_UNKNOWN, 16'd1,
		SEED_UNKNOWN, 16'd9,        SEED_UNKNOWN, 16'd5
	};

	// Control and payload handed from the input stage to the mask unit.
	typedef struct packed {
		logic              fire;
		logic              op;
		logic [WORD_W-1:0] cipher_word;
		logic [SEED_W-1:0] seed_index;
	} step_t;

	function automatic logic [WORD_W-1:0] permute(input logic [WORD_W-1:0] v,
	                                              input perm_t tab);
		logic [WORD_W-1:0] r;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			r[15-k] = v[tab[k]];
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] seed_value(input logic [SEED_W-1:0] idx);
		return SEED_TABLE[idx];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/swuck_in_if.sv -----
// ----------------------------------------------------------------------------
// swuck_in_if
// Input channel: one decrypt or reinitialise item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface swuck_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] cipher_word;
	logic [3:0]  seed_index;

	modport source (output valid, output op, output cipher_word, output seed_index,
	                input ready);
	modport sink   (input valid, input op, input cipher_word, input seed_index,
	                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swuck_out_if.sv -----
// ----------------------------------------------------------------------------
// swuck_out_if
// Output channel: one decrypted word per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface swuck_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] plain_word;

	modport source (output valid, output plain_word, input ready);
	modport sink   (input valid, input plain_word, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swuck_mask_unit.sv -----
// ----------------------------------------------------------------------------
// swuck_mask_unit
// Holds the running mask and word counter, unmasks one word per decrypt step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_word_unmasker_counter_keyed_assert.svh"

module swuck_mask_unit
	import swuck_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire step_t             step,
	output logic      [WORD_W-1:0] plain_word
);

	logic [WORD_W-1:0]  mask_q;
	logic [COUNT_W-1:0] count_q;
	logic [WORD_W-1:0]  term;
	logic [WORD_W-1:0]  mask_next;
	logic [WORD_W-1:0]  c;
	logic [COUNT_W-1:0] n;

	assign c = step.cipher_word;
	assign n = count_q;

	assign plain_word = mask_q ^ permute(c, PERM_IN);

	// Term vector mixing cipher bits with counter bits.
	always_comb begin
		term     = '0;
		term[15] = n[4];
		term[14] = c[2] ^ c[5];
		term[13] = c[0];
		term[12] = c[4] | c[5];
		term[11] = n[0];
		term[10] = c[6];
		term[8]  = c[4] & n[1];
		term[6]  = n[3];
		term[5]  = c[3] | n[7];
		term[4]  = c[2] ^ n[3];
		term[3]  = n[2];
		term[2]  = c[7] & n[7];
		term[1]  = n[5];
		term[0]  = c[7] | n[1];
		mask_next = term ^ permute(c, PERM_C) ^ permute(plain_word, PERM_P) ^ MASK_CONST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			count_q <= '0;
		end else if (step.fire) begin
			if (step.op == OP_INIT) begin
				mask_q  <= seed_value(step.seed_index);
				count_q <= '0;
			end else begin
				mask_q  <= mask_next;
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	`SWUCK_ASSERT_NEXT(a_init_loads_seed, clk, arst_n, step.fire && step.op == OP_INIT,
		mask_q == seed_value($past(step.seed_index)) && count_q == '0)
	`SWUCK_ASSERT_NEXT(a_decrypt_counts, clk, arst_n, step.fire && step.op == OP_DECRYPT,
		count_q == COUNT_W'($past(count_q) + COUNT_W'(1)))
	`SWUCK_ASSERT_NEXT(a_idle_holds, clk, arst_n, !step.fire,
		$stable(mask_q) && $stable(count_q))

endmodule

`default_nettype wire

// ----- hw/rtl/serial_word_unmasker_counter_keyed.sv -----
// ----------------------------------------------------------------------------
// serial_word_unmasker_counter_keyed
// Serial 16-bit word unmasker with a seedable mask and an 8-bit word counter.
// ----------------------------------------------------------------------------
// A decrypt item is unmasked as it moves from the input register into the output register.
// Throughput: one item per cycle unless a decrypt item waits on a stalled output. The
// input and output registers form two stages; the mask recurrence closes in the second.
// Reset (arst_n low, asynchronous): mask and counter clear to zero, both stages empty.
// Reinitialise items leave the input stage without an output slot and produce no result.
`default_nettype none

`include "serial_word_unmasker_counter_keyed_assert.svh"

module serial_word_unmasker_counter_keyed
	import swuck_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	swuck_in_if.sink   din,
	swuck_out_if.source dout
);

	// Input stage: the item waits here until the mask unit may consume it.
	logic              valid_s1;
	logic              op_s1;
	logic [WORD_W-1:0] cipher_s1;
	logic [SEED_W-1:0] seed_s1;

	// Output register.
	logic              out_valid_q;
	logic [WORD_W-1:0] plain_q;

	logic              out_free;
	logic              adv_s1;
	step_t             step;
	logic [WORD_W-1:0] plain_word;

	// The output register can take a new word when it is empty or being
	// drained in this cycle. A reinitialise item needs no output slot, so it
	// always leaves the input stage at once.
	assign out_free = !out_valid_q || dout.ready;
	assign adv_s1   = valid_s1 && (op_s1 == OP_INIT || out_free);
	assign din.ready = !valid_s1 || adv_s1;

	assign step.fire        = adv_s1;
	assign step.op          = op_s1;
	assign step.cipher_word = cipher_s1;
	assign step.seed_index  = seed_s1;

	swuck_mask_unit u_mask (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.plain_word (plain_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			op_s1     <= din.op;
			cipher_s1 <= din.cipher_word;
			seed_s1   <= din.seed_index;
		end
	end

	// A decrypt step loads the output register; otherwise a completed
	// transfer empties it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && op_s1 == OP_DECRYPT) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && op_s1 == OP_DECRYPT) begin
			plain_q <= plain_word;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.plain_word = plain_q;

	// A decrypt step always leaves a word waiting on the output.
	`SWUCK_ASSERT_NEXT(a_decrypt_shows, clk, arst_n, adv_s1 && op_s1 == OP_DECRYPT,
		out_valid_q)
	// A reinitialise step never invents a result on a drained output.
	`SWUCK_ASSERT_NEXT(a_init_silent, clk, arst_n,
		adv_s1 && op_s1 == OP_INIT && dout.ready,
		!out_valid_q)
	// A decrypt item blocked by a stalled output stays in the input stage.
	`SWUCK_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n,
		valid_s1 && op_s1 == OP_DECRYPT && out_valid_q && !dout.ready,
		valid_s1 && $stable(cipher_s1))

endmodule

`default_nettype wire

// ----- sim/tb_serial_word_unmasker_counter_keyed.sv -----
// ----------------------------------------------------------------------------
// tb_serial_word_unmasker_counter_keyed
// Self-checking bench for the serial word unmasker. Decrypt and reinitialise
// items are streamed through the input channel. A behavioural copy of the
// mask recurrence predicts every plain word, and each output transfer is
// checked against it in order. Three idle settings are run, the last with none.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_serial_word_unmasker_counter_keyed;
	import swuck_pkg::OP_DECRYPT;
	import swuck_pkg::OP_INIT;

	// Idle time for the block to settle after the last owed word.
	localparam int unsigned SETTLE_CYCLES = 6;
	// The slowest correct run sends about 2000 items; the limit sits well
	// above the cycles that such a run needs.
	localparam int unsigned CYCLE_LIMIT   = 400000;

	// Bit orders of the three scrambles. Nibble k, counted from the top, names
	// the source bit of result bit 15-k.
	localparam logic [63:0] ORDER_CIPHER_IN  = 64'h9DF7_E86A_BC35_0142;
	localparam logic [63:0] ORDER_CIPHER_FB  = 64'h6B31_D5FA_2984_0C7E;
	localparam logic [63:0] ORDER_PLAIN_FB   = 64'h9752_E4D8_0FA1_36CB;
	localparam logic [15:0] FEEDBACK_CONST   = 16'hecbe;
	localparam logic [15:0] SEED_NOT_KNOWN   = 16'd16;

	logic clk;
	logic arst_n;

	swuck_in_if  din_if ();
	swuck_out_if dout_if ();

	serial_word_unmasker_counter_keyed i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	// Shadow state of the unmasker. It is updated at each accepted input
	// transfer.
	logic [15:0] mask_shadow  = '0;
	logic [7:0]  count_shadow = '0;

	// Plain words still owed by the block, oldest first.
	logic [15:0] plain_expected [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned error_count    = 0;
	int unsigned words_checked  = 0;
	int unsigned reinit_count   = 0;
	int unsigned wrap_count     = 0;
	int unsigned cycle_count    = 0;
	logic [15:0] plain_front;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Generous watchdog. A hang or a missing word ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still expected",
			         cycle_count, plain_expected.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver stalls at random. The draw is made at the falling edge, so
	// ready is stable when the block samples it.
	always @(negedge clk) begin
		dout_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Output checker. Every output transfer is compared with the oldest
	// predicted word.
	always @(posedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (plain_expected.size() == 0) begin
				$error("plain_word: no word expected, actual 0x%04h", dout_if.plain_word);
				error_count++;
			end else begin
				plain_front = plain_expected.pop_front();
				words_checked++;
				if (dout_if.plain_word !== plain_front) begin
					$error("plain_word: expected 0x%04h, actual 0x%04h",
					       plain_front, dout_if.plain_word);
					error_count++;
				end
			end
		end
	end

	// Applies a nibble-coded bit order to a word.
	function automatic logic [15:0] scatter_bits(input logic [15:0] v, input logic [63:0] order);
		logic [15:0] r;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			r[15-k] = v[order[63-4*k -: 4]];
		end
		return r;
	endfunction

	// Seed store. Entries that are not known load the value 16.
	function automatic logic [15:0] seed_word(input logic [3:0] idx);
		case (idx)
			4'd3:    return 16'd0;
			4'd4:    return 16'd4;
			4'd5:    return 16'd9;
			4'd9:    return 16'd8;
			4'd11:   return 16'd1;
			4'd13:   return 16'd9;
			4'd15:   return 16'd5;
			default: return SEED_NOT_KNOWN;
		endcase
	endfunction

	// Advances the shadow state by one accepted item. A decrypt item queues
	// its plain word.
	function automatic void advance_unmasker(input logic op, input logic [15:0] c,
	                                         input logic [3:0] idx);
		logic [15:0] plain;
		logic [15:0] terms;
		logic [7:0]  n;
		n = count_shadow;
		if (op == OP_INIT) begin
			mask_shadow  = seed_word(idx);
			count_shadow = '0;
			reinit_count++;
		end else begin
			plain = mask_shadow ^ scatter_bits(c, ORDER_CIPHER_IN);
			// The bit terms are taken from the cipher word and the counter.
			// Bits 9 and 7 stay zero.
			terms      = '0;
			terms[15]  = n[4];
			terms[14]  = c[2] ^ c[5];
			terms[13]  = c[0];
			terms[12]  = c[4] | c[5];
			terms[11]  = n[0];
			terms[10]  = c[6];
			terms[8]   = c[4] & n[1];
			terms[6]   = n[3];
			terms[5]   = c[3] | n[7];
			terms[4]   = c[2] ^ n[3];
			terms[3]   = n[2];
			terms[2]   = c[7] & n[7];
			terms[1]   = n[5];
			terms[0]   = c[7] | n[1];
			mask_shadow = terms ^ scatter_bits(c, ORDER_CIPHER_FB)
			            ^ scatter_bits(plain, ORDER_PLAIN_FB) ^ FEEDBACK_CONST;
			if (count_shadow == 8'hff) begin
				wrap_count++;
			end
			count_shadow = count_shadow + 8'd1;
			plain_expected.push_back(plain);
		end
	endfunction

	// Sends one item. The task is entered and left at a falling edge. Valid
	// stays high after a transfer and is lowered only while the sender idles.
	// This keeps back-to-back items free of a lower-and-raise in one step.
	task automatic send_item(input logic op, input logic [15:0] c, input logic [3:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			din_if.valid <= 1'b0;
			@(negedge clk);
		end
		din_if.valid       <= 1'b1;
		din_if.op          <= op;
		din_if.cipher_word <= c;
		din_if.seed_index  <= idx;
		@(posedge clk);
		while (!din_if.ready) begin
			@(posedge clk);
		end
		advance_unmasker(op, c, idx);
		@(negedge clk);
	endtask

	// The unused field of each item carries random bits, which the block must
	// ignore.
	task automatic send_decrypt(input logic [15:0] c);
		send_item(OP_DECRYPT, c, 4'($urandom_range(15)));
	endtask

	task automatic send_reinit(input logic [3:0] idx);
		send_item(OP_INIT, 16'($urandom), idx);
	endtask

	// Directed items. The first words run from the reset mask. Then come
	// extreme and walking cipher words, known and unknown seeds, and two
	// reinitialise items in a row.
	task automatic test_directed();
		send_decrypt(16'h0000);
		send_decrypt(16'hffff);
		send_decrypt(16'haaaa);
		send_decrypt(16'h5555);
		send_item(OP_INIT, 16'hffff, 4'd0);
		send_item(OP_DECRYPT, 16'h0001, 4'hf);
		send_reinit(4'd3);
		send_decrypt(16'h8000);
		send_reinit(4'd15);
		send_item(OP_DECRYPT, 16'hffff, 4'hf);
		send_reinit(4'd14);
		send_reinit(4'd5);
		send_decrypt(16'h00ff);
		send_decrypt(16'hff00);
		send_decrypt(16'h0004);
		send_decrypt(16'h0010);
		send_decrypt(16'h0020);
		send_decrypt(16'h0080);
	endtask

	// Random streams. Most of them are a reinitialise item followed by a run of
	// decrypts. Runs are mostly short, with a few long enough to take the
	// counter past bit 7. Some runs carry on from the old state without a
	// reinitialise item, and stray reinitialise items fall inside runs.
	task automatic test_random_streams(input int unsigned n_items);
		int unsigned sent;
		int unsigned run_len;
		int unsigned pick;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				run_len = $urandom_range(40, 1);
			end else if (pick < 97) begin
				run_len = $urandom_range(200, 41);
			end else begin
				run_len = $urandom_range(320, 256);
			end
			if ($urandom_range(9) != 0) begin
				send_reinit(4'($urandom_range(15)));
				sent++;
			end
			for (int unsigned i = 0; i < run_len; i++) begin
				if ($urandom_range(99) < 2) begin
					send_reinit(4'($urandom_range(15)));
					sent++;
				end
				send_decrypt(16'($urandom));
				sent++;
			end
		end
	endtask

	// The sender stops until every owed word has arrived and the block has
	// settled. It then resumes into an idle block.
	task automatic test_drain_pause();
		send_reinit(4'($urandom_range(15)));
		for (int i = 0; i < 20; i++) begin
			send_decrypt(16'($urandom));
		end
		din_if.valid <= 1'b0;
		while (plain_expected.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		for (int i = 0; i < 20; i++) begin
			send_decrypt(16'($urandom));
		end
	endtask

	// One unbroken run of 300 words after a reinitialise item. The counter
	// wraps from 255 to 0, and its top bit is set for 128 of the words.
	task automatic test_counter_wrap();
		send_reinit(4'($urandom_range(15)));
		for (int i = 0; i < 300; i++) begin
			send_decrypt(16'($urandom));
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		din_if.valid        = 1'b0;
		din_if.op           = OP_DECRYPT;
		din_if.cipher_word  = '0;
		din_if.seed_index   = '0;
		dout_if.ready       = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First the sender idles rarely and the receiver stalls often.
		send_idle_pct  = 7;
		recv_stall_pct = 77;
		test_directed();
		test_random_streams(450);

		// Then the other way round.
		send_idle_pct  = 77;
		recv_stall_pct = 7;
		test_drain_pause();
		test_random_streams(450);

		// Then neither side idles.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_counter_wrap();
		test_random_streams(350);

		din_if.valid <= 1'b0;
		while (plain_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d plain words across %0d reinitialise items and %0d counter wraps,",
		         words_checked, reinit_count, wrap_count);
		$display("under three sender and receiver idle settings, with one full drain pause.");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- serial_word_unmasker_counter_keyed.f -----
+incdir+hw/rtl
hw/rtl/swuck_pkg.sv
hw/rtl/swuck_in_if.sv
hw/rtl/swuck_out_if.sv
hw/rtl/swuck_mask_unit.sv
hw/rtl/serial_word_unmasker_counter_keyed.sv
sim/tb_serial_word_unmasker_counter_keyed.sv
